FILE: hw/rtl/ttb_pkg.sv
// ----------------------------------------------------------------------------
// ttb_pkg
// Shared constants and types for the tangent basis block.
// ----------------------------------------------------------------------------
package ttb_pkg;

  localparam int PosWidthDef = 32;
  localparam int TexW        = 16;
  localparam int OutW        = 16;
  // Edge differences are at most POS_WIDTH+1 bits, UV deltas 17 bits, so
  // each product term fits 50 bits and the tangent component 51 bits.
  localparam int CompW       = 52;
  localparam int MagW        = 30;
  localparam int SumW        = 62;
  localparam int RootW       = 31;
  localparam logic [OutW-1:0] OneQ14 = 16'd16384;

  // Sequencer codes shared with the divide/root unit
  localparam logic [1:0] OpSqrt = 2'd0;
  localparam logic [1:0] OpDiv  = 2'd1;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } ttb_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ttb_sts_t;

endpackage

FILE: hw/rtl/ttb_if.sv
// ----------------------------------------------------------------------------
// ttb_in_if / ttb_out_if
// Valid/ready channels for vertex requests and face results.
// ----------------------------------------------------------------------------
interface ttb_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [15:0] tex_u;
  logic signed [15:0] tex_v;
  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

interface ttb_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] tangent_x;
  logic signed [15:0] tangent_y;
  logic signed [15:0] tangent_z;
  logic signed [15:0] bitangent_x;
  logic signed [15:0] bitangent_y;
  logic signed [15:0] bitangent_z;
  logic               degenerate;
  modport source (output valid, tangent_x, tangent_y, tangent_z, bitangent_x,
                  bitangent_y, bitangent_z, degenerate, input ready);
  modport sink   (input valid, tangent_x, tangent_y, tangent_z, bitangent_x,
                  bitangent_y, bitangent_z, degenerate, output ready);
endinterface

FILE: hw/rtl/triangle_tangent_basis_top.sv
// ----------------------------------------------------------------------------
// triangle_tangent_basis_top
// Per-face tangent and bitangent from vertex positions and UVs.
// ----------------------------------------------------------------------------
// First and second vertex of a face: accepted and held, no result.
// Third vertex: result follows the normalizing shifts of each vector and the
// work of the shared one-bit-per-cycle divide/root unit (two roots, six
// divides); a degenerate face skips the unit. Ready is low from the third
// vertex until its result is taken. Synchronous active-low reset clears the
// vertex slot and handshake state; held vertices are undefined until written.
module triangle_tangent_basis_top
  import ttb_pkg::*;
#(
  parameter int POS_WIDTH = PosWidthDef
)(
  input logic    clk,
  input logic    rst_n,
  ttb_in_if.sink   in_ch,
  ttb_out_if.source out_ch
);

  localparam int EW = POS_WIDTH + 1;

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StMul  = 4'd1;
  localparam logic [3:0] StSum  = 4'd2;
  localparam logic [3:0] StNorm = 4'd3;
  localparam logic [3:0] StSq   = 4'd4;
  localparam logic [3:0] StRoot = 4'd5;
  localparam logic [3:0] StDiv  = 4'd6;
  localparam logic [3:0] StOut  = 4'd7;

  logic [3:0] st_r, st_nxt;
  logic [1:0] slot_r;
  logic [POS_WIDTH-1:0] hp_r [6];
  logic [TexW-1:0]      ht_r [4];

  logic signed [EW-1:0]     e1_r [3];
  logic signed [EW-1:0]     e2_r [3];
  logic signed [TexW:0]     du1_r, dv1_r, du2_r, dv2_r;
  logic signed [CompW-1:0]  c_r [6];
  logic signed [34:0]       det_r;
  logic [1:0]  mstep_r;
  logic        vsel_r;     // 0 tangent, 1 bitangent
  logic [1:0]  ci_r;
  logic [CompW-1:0] m_r [3];
  logic [RootW-1:0] len_r;
  logic [OutW-1:0]  q_r [6];
  logic [SumW-1:0]  sum_r;
  logic             degen_r;
  logic             out_v_r;

  ttb_cmd_t cmd;
  ttb_sts_t sts;
  logic [SumW-1:0]  u_a;
  logic [RootW-1:0] u_b;
  logic [RootW-1:0] u_res;

  ttb_divsqrt u_ds (.clk, .rst_n, .cmd, .opa(u_a), .opb(u_b), .sts, .res(u_res));

  logic acc;
  assign in_ch.ready = (st_r == StIdle);
  assign acc = in_ch.valid && in_ch.ready;

  // Operand extraction of the current request
  logic signed [POS_WIDTH-1:0] ip [3];
  assign ip[0] = in_ch.pos_x[POS_WIDTH-1:0];
  assign ip[1] = in_ch.pos_y[POS_WIDTH-1:0];
  assign ip[2] = in_ch.pos_z[POS_WIDTH-1:0];

  // First held entry of the current slot
  logic [2:0] pbase;
  assign pbase = slot_r[0] ? 3'd3 : 3'd0;

  // Max magnitude and normalize shift direction
  logic [CompW-1:0] mx;
  always_comb begin
    mx = m_r[0];
    if (m_r[1] > mx) mx = m_r[1];
    if (m_r[2] > mx) mx = m_r[2];
  end

  logic signed [CompW-1:0] cur [3];
  always_comb begin
    for (int i = 0; i < 3; i++) cur[i] = vsel_r ? c_r[3+i] : c_r[i];
  end

  // Products for the current axis (four multipliers, one axis per cycle)
  logic signed [CompW-1:0] pt, pb;
  logic [1:0] ax;
  logic signed [EW+TexW:0] pr_a, pr_b, pr_c, pr_d;
  assign ax = mstep_r;
  assign pr_a = e1_r[ax] * dv2_r;
  assign pr_b = e2_r[ax] * dv1_r;
  assign pr_c = e2_r[ax] * du1_r;
  assign pr_d = e1_r[ax] * du2_r;
  always_comb begin
    pt = CompW'(pr_a) - CompW'(pr_b);
    pb = CompW'(pr_c) - CompW'(pr_d);
  end

  // UV determinant products
  logic signed [2*TexW+1:0] pd_a, pd_b;
  assign pd_a = du1_r * dv2_r;
  assign pd_b = dv1_r * du2_r;

  logic [2*MagW-1:0] sq_full;
  logic [SumW-1:0]   sq;
  assign sq_full = m_r[ci_r][MagW-1:0] * m_r[ci_r][MagW-1:0];
  assign sq      = SumW'(sq_full);

  logic [1:0] slot_idx;
  assign slot_idx = (ci_r == 2'd3) ? 2'd0 : ci_r;

  always_comb begin
    cmd.start = 1'b0;
    cmd.op    = OpSqrt;
    u_a       = sum_r;
    u_b       = len_r;
    if (st_r == StSq && ci_r == 2'd3) cmd.start = 1'b1;
    if (st_r == StRoot && sts.done) begin
      cmd.start = 1'b1;
      cmd.op    = OpDiv;
    end
    if (st_r == StDiv && sts.done && ci_r != 2'd2) begin
      cmd.start = 1'b1;
      cmd.op    = OpDiv;
    end
    if (cmd.op == OpDiv) begin
      u_a = SumW'({m_r[slot_idx][MagW-1:0], 14'd0}) + SumW'(u_res >> 1);
      u_b = u_res;
      if (st_r == StDiv) begin
        u_a = SumW'({m_r[ci_r+2'd1][MagW-1:0], 14'd0}) + SumW'(len_r >> 1);
        u_b = len_r;
      end
    end
  end

  logic [OutW-1:0] qcap;
  logic [OutW-1:0] qsig;
  logic [2:0]      qidx;
  assign qcap = (u_res > RootW'(OneQ14)) ? OneQ14 : u_res[OutW-1:0];
  assign qsig = cur[ci_r][CompW-1] ? (OutW'(0) - qcap) : qcap;
  assign qidx = (vsel_r ? 3'd3 : 3'd0) + {1'b0, ci_r};

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      StIdle: if (acc && slot_r == 2'd2) st_nxt = StMul;
      StMul:  if (mstep_r == 2'd2) st_nxt = StSum;
      StSum:  st_nxt = StNorm;
      StNorm: if (degen_r) st_nxt = StOut;
              else if (!(mx >= (CompW'(1) << MagW)) && (mx >= (CompW'(1) << (MagW-1))))
                st_nxt = StSq;
      StSq:   if (ci_r == 2'd3) st_nxt = StRoot;
      StRoot: if (sts.done) st_nxt = StDiv;
      StDiv:  if (sts.done && ci_r == 2'd2) st_nxt = vsel_r ? StOut : StNorm;
      StOut:  if (out_v_r && out_ch.ready) st_nxt = StIdle;
      default: st_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= StIdle;
      slot_r  <= 2'd0;
      out_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (acc) slot_r <= (slot_r == 2'd2) ? 2'd0 : slot_r + 2'd1;
      if (st_r != StOut && st_nxt == StOut) out_v_r <= 1'b1;
      else if (out_v_r && out_ch.ready) out_v_r <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (st_r)
      StIdle: begin
        if (acc && slot_r != 2'd2) begin
          for (int a = 0; a < 3; a++) hp_r[pbase + 3'(a)] <= ip[a];
          ht_r[{slot_r[0], 1'b0}] <= in_ch.tex_u;
          ht_r[{slot_r[0], 1'b1}] <= in_ch.tex_v;
        end
        if (acc && slot_r == 2'd2) begin
          for (int a = 0; a < 3; a++) begin
            e1_r[a] <= EW'($signed(hp_r[3+a])) - EW'($signed(hp_r[a]));
            e2_r[a] <= EW'(ip[a]) - EW'($signed(hp_r[a]));
          end
          du1_r <= 17'($signed(ht_r[2])) - 17'($signed(ht_r[0]));
          dv1_r <= 17'($signed(ht_r[3])) - 17'($signed(ht_r[1]));
          du2_r <= 17'(in_ch.tex_u) - 17'($signed(ht_r[0]));
          dv2_r <= 17'(in_ch.tex_v) - 17'($signed(ht_r[1]));
          mstep_r <= 2'd0;
          vsel_r  <= 1'b0;
        end
      end
      StMul: begin
        c_r[{1'b0, ax}]          <= pt;
        c_r[3'd3 + {1'b0, ax}]   <= pb;
        mstep_r   <= mstep_r + 2'd1;
        if (mstep_r == 2'd0) det_r <= 35'(pd_a) - 35'(pd_b);
      end
      StSum: begin
        // Apply sign of det, flag degenerate faces, take tangent magnitudes
        for (int i = 0; i < 6; i++)
          if (det_r < 0) c_r[i] <= -c_r[i];
        degen_r <= (det_r == 0) || (c_r[0] == 0 && c_r[1] == 0 && c_r[2] == 0)
                   || (c_r[3] == 0 && c_r[4] == 0 && c_r[5] == 0);
        for (int i = 0; i < 3; i++)
          m_r[i] <= c_r[i][CompW-1] ? -c_r[i] : c_r[i];
        ci_r  <= 2'd0;
        sum_r <= '0;
      end
      StNorm: begin
        // Shift magnitudes one bit per cycle toward [2^29, 2^30)
        if (mx >= (CompW'(1) << MagW))
          for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] >> 1;
        else if (mx < (CompW'(1) << (MagW-1)))
          for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] << 1;
        ci_r  <= 2'd0;
        sum_r <= '0;
        if (degen_r) for (int i = 0; i < 6; i++) q_r[i] <= '0;
      end
      StSq: begin
        if (ci_r != 2'd3) begin
          sum_r <= sum_r + sq;
          ci_r  <= ci_r + 2'd1;
        end else ci_r <= 2'd0;
      end
      StRoot: if (sts.done) len_r <= u_res;
      StDiv: begin
        if (sts.done) begin
          q_r[qidx] <= qsig;
          if (ci_r == 2'd2) begin
            ci_r   <= 2'd0;
            vsel_r <= 1'b1;
            for (int i = 0; i < 3; i++)
              m_r[i] <= c_r[3+i][CompW-1] ? -c_r[3+i] : c_r[3+i];
          end else ci_r <= ci_r + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.tangent_x   = q_r[0];
  assign out_ch.tangent_y   = q_r[1];
  assign out_ch.tangent_z   = q_r[2];
  assign out_ch.bitangent_x = q_r[3];
  assign out_ch.bitangent_y = q_r[4];
  assign out_ch.bitangent_z = q_r[5];
  assign out_ch.degenerate  = degen_r;

  // Checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != StIdle) |-> !in_ch.ready) else $error("request taken while busy");
  a_out_only_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (st_r == StOut)) else $error("result outside output state");
  a_unit_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !sts.busy) else $error("unit busy during output");

endmodule

FILE: hw/rtl/ttb_divsqrt.sv
// ----------------------------------------------------------------------------
// ttb_divsqrt
// Shared radix-2 unit: integer square root of a 62-bit sum, or division of a
// 45-bit dividend by a 31-bit divisor. One result bit per cycle.
// ----------------------------------------------------------------------------
module ttb_divsqrt
  import ttb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  ttb_cmd_t          cmd,
  input  logic [SumW-1:0]   opa,
  input  logic [RootW-1:0]  opb,
  output ttb_sts_t          sts,
  output logic [RootW-1:0]  res
);

  localparam int DivBits = 45;
  localparam int CntW    = 6;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [1:0]       op_r, op_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic [SumW+1:0]  rem_r, rem_nxt;
  logic [SumW-1:0]  src_r, src_nxt;
  logic [DivBits-1:0] quo_r, quo_nxt;
  logic [RootW-1:0] dvs_r, dvs_nxt;
  logic [SumW+1:0]  trial;
  logic [SumW+1:0]  shifted;

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign res      = quo_r[RootW-1:0];

  // One step per cycle: shift in the next bits, trial subtract, keep a bit
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    src_nxt  = src_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    shifted  = '0;
    trial    = '0;
    if (cmd.start) begin
      busy_nxt = 1'b1;
      op_nxt   = cmd.op;
      rem_nxt  = '0;
      src_nxt  = opa;
      quo_nxt  = '0;
      dvs_nxt  = opb;
      cnt_nxt  = (cmd.op == OpSqrt) ? CntW'(RootW) : CntW'(DivBits);
    end else if (busy_r) begin
      if (op_r == OpSqrt) begin
        shifted = {rem_r[SumW-1:0], src_r[SumW-1:SumW-2]};
        trial   = {{(SumW-DivBits){1'b0}}, quo_r, 2'b01};
        src_nxt = {src_r[SumW-3:0], 2'b00};
      end else begin
        shifted = {rem_r[SumW:0], src_r[DivBits-1]};
        trial   = {{(SumW+2-RootW){1'b0}}, dvs_r};
        src_nxt = {src_r[SumW-2:0], 1'b0};
      end
      if (shifted >= trial) begin
        rem_nxt = shifted - trial;
        quo_nxt = {quo_r[DivBits-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[DivBits-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r  <= op_nxt;
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    src_r <= src_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for triangle_tangent_basis_top. Vertex requests are
// queued by a stimulus block and driven with random idle bursts; face results
// are checked field by field against an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [15:0] tu;
    logic signed [15:0] tv;
  } vertex_t;

  typedef struct packed {
    logic signed [15:0] tx;
    logic signed [15:0] ty;
    logic signed [15:0] tz;
    logic signed [15:0] bx;
    logic signed [15:0] by;
    logic signed [15:0] bz;
    logic               degen;
  } basis_t;

  logic clk;
  logic rst_n;
  ttb_in_if  in_ch();
  ttb_out_if out_ch();

  triangle_tangent_basis_top u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  vertex_t pending_verts[$];
  basis_t  expected_bases[$];
  int      error_count;
  bit      quiet_phase;
  bit      hold_sender;
  bit      stim_done;

  // predictor state
  logic signed [31:0] held_pos[6];
  logic signed [15:0] held_uv[4];
  int                 slot;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] MISMATCH %s: got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Append a vertex request to the pending queue
  task automatic add_vertex(input vertex_t v);
    pending_verts.insert(pending_verts.size(), v);
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Scale a nonzero vector to a Q2.14 unit vector
  task automatic to_unit_q14(input longint c[3], output logic signed [15:0] q[3]);
    longint unsigned mag[3];
    longint unsigned mx, s, len, v;
    mx = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (c[i] < 0) ? longint'(-c[i]) : longint'(c[i]);
      if (mag[i] > mx) mx = mag[i];
    end
    while (mx >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
      mx >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
      mx <<= 1;
    end
    for (int i = 0; i < 3; i++) s += mag[i] * mag[i];
    len = int_sqrt(s);
    for (int i = 0; i < 3; i++) begin
      v = (mag[i] * 16384 + (len >> 1)) / len;
      if (v > 16384) v = 16384;
      if (c[i] < 0) v = -v;
      q[i] = v[15:0];
    end
  endtask

  // Advance the vertex slot; on the closing vertex, predict the face basis
  task automatic predict_face(input vertex_t v);
    longint p0[3], p1[3], p2[3], e1[3], e2[3], tg[3], bt[3];
    longint du1, dv1, du2, dv2, det;
    logic signed [15:0] qt[3], qb[3];
    bit tzero, bzero;
    basis_t r;
    if (slot < 2) begin
      held_pos[slot*3]   = v.px;
      held_pos[slot*3+1] = v.py;
      held_pos[slot*3+2] = v.pz;
      held_uv[slot*2]    = v.tu;
      held_uv[slot*2+1]  = v.tv;
      slot++;
      return;
    end
    slot = 0;
    for (int a = 0; a < 3; a++) begin
      p0[a] = held_pos[a];
      p1[a] = held_pos[3+a];
    end
    p2[0] = v.px;
    p2[1] = v.py;
    p2[2] = v.pz;
    du1 = longint'(held_uv[2]) - longint'(held_uv[0]);
    dv1 = longint'(held_uv[3]) - longint'(held_uv[1]);
    du2 = longint'(v.tu) - longint'(held_uv[0]);
    dv2 = longint'(v.tv) - longint'(held_uv[1]);
    det = du1 * dv2 - dv1 * du2;
    tzero = 1;
    bzero = 1;
    for (int a = 0; a < 3; a++) begin
      e1[a] = p1[a] - p0[a];
      e2[a] = p2[a] - p0[a];
      tg[a] = e1[a] * dv2 - e2[a] * dv1;
      bt[a] = e2[a] * du1 - e1[a] * du2;
      if (det < 0) begin
        tg[a] = -tg[a];
        bt[a] = -bt[a];
      end
      if (tg[a] != 0) tzero = 0;
      if (bt[a] != 0) bzero = 0;
    end
    r = '0;
    if (det == 0 || tzero || bzero) begin
      r.degen = 1'b1;
    end else begin
      to_unit_q14(tg, qt);
      to_unit_q14(bt, qb);
      r.tx = qt[0]; r.ty = qt[1]; r.tz = qt[2];
      r.bx = qb[0]; r.by = qb[1]; r.bz = qb[2];
    end
    expected_bases.insert(expected_bases.size(), r);
  endtask

  function automatic vertex_t make_vertex(input logic [31:0] x, input logic [31:0] y,
                                          input logic [31:0] z, input logic [15:0] u,
                                          input logic [15:0] v);
    vertex_t t;
    t.px = x; t.py = y; t.pz = z; t.tu = u; t.tv = v;
    return t;
  endfunction

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2000)) - 1000);
      2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 5)
                                           : 32'h8000_0000 + $urandom_range(0, 5);
    endcase
  endfunction

  function automatic logic [15:0] rand_uv();
    case ($urandom_range(0, 2))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 40)) - 20);
      default: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    endcase
  endfunction

  // Fill the vertex queue: directed faces first, then random faces
  initial begin
    vertex_t v0, v1, v2;
    error_count = 0;
    quiet_phase = 0;
    hold_sender = 0;
    stim_done = 0;
    // unit right triangle, regular basis
    add_vertex(make_vertex(0, 0, 0, 0, 0));
    add_vertex(make_vertex(32'h10000, 0, 0, 16'h1000, 0));
    add_vertex(make_vertex(0, 32'h10000, 0, 0, 16'h1000));
    // zero determinant: collinear UVs
    add_vertex(make_vertex(0, 0, 0, 0, 0));
    add_vertex(make_vertex(32'h10000, 0, 0, 16'h1000, 16'h1000));
    add_vertex(make_vertex(0, 32'h10000, 0, 16'h2000, 16'h2000));
    // zero raw tangent: all positions equal, nonzero determinant
    add_vertex(make_vertex(5, 5, 5, 0, 0));
    add_vertex(make_vertex(5, 5, 5, 16'h1000, 0));
    add_vertex(make_vertex(5, 5, 5, 0, 16'h1000));
    // negative determinant, extreme positions and UVs
    add_vertex(make_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                           16'h7FFF, 16'h8000));
    add_vertex(make_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                           16'h8000, 16'h8000));
    add_vertex(make_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                           16'h7FFF, 16'h7FFF));
    // all ones and all zeros
    add_vertex(make_vertex('1, '1, '1, '1, '1));
    add_vertex(make_vertex(0, 0, 0, 0, 0));
    add_vertex(make_vertex(1, 32'hFFFF_FFFF, 2, 1, 16'hFFFF));
    // tiny edges
    add_vertex(make_vertex(0, 0, 0, 0, 0));
    add_vertex(make_vertex(1, 0, 0, 1, 0));
    add_vertex(make_vertex(0, 0, 1, 0, 1));
    for (int f = 0; f < 210; f++) begin
      if (f % 10 == 9) begin
        v0 = make_vertex(rand_pos(), rand_pos(), rand_pos(), rand_uv(), rand_uv());
        v1 = v0;
        v2 = make_vertex(rand_pos(), rand_pos(), rand_pos(), v0.tu, v0.tv);
      end else begin
        v0 = make_vertex(rand_pos(), rand_pos(), rand_pos(), rand_uv(), rand_uv());
        v1 = make_vertex(rand_pos(), rand_pos(), rand_pos(), rand_uv(), rand_uv());
        v2 = make_vertex(rand_pos(), rand_pos(), rand_pos(), rand_uv(), rand_uv());
      end
      add_vertex(v0);
      add_vertex(v1);
      add_vertex(v2);
    end
    stim_done = 1;
  end

  // Sequence the run phases from the driver's progress
  initial begin
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_verts.size() < 400);
    hold_sender = 1;
    wait (expected_bases.size() == 0);
    @(posedge clk);
    hold_sender = 0;
    wait (pending_verts.size() < 60);
    quiet_phase = 1;
    wait (stim_done && pending_verts.size() == 0 && !in_ch.valid);
    wait (expected_bases.size() == 0);
    repeat (400) @(posedge clk);
    if (error_count == 0 && expected_bases.size() == 0) begin
      $display("triangle_tangent_basis_top verification clean");
    end else begin
      $display("triangle_tangent_basis_top verification failed");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("triangle_tangent_basis_top verification failed");
    $finish;
  end

  // Drive vertex requests with random idle bursts
  int idle_in;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.pos_x <= '0;
      in_ch.pos_y <= '0;
      in_ch.pos_z <= '0;
      in_ch.tex_u <= '0;
      in_ch.tex_v <= '0;
      idle_in = 0;
      slot = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_face({in_ch.pos_x, in_ch.pos_y, in_ch.pos_z, in_ch.tex_u, in_ch.tex_v});
        if (!quiet_phase && $urandom_range(0, 5) == 0) idle_in = $urandom_range(1, 12);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (idle_in > 0) begin
          idle_in--;
          in_ch.valid <= 1'b0;
        end else if (!hold_sender && pending_verts.size() > 0) begin
          vertex_t nv;
          nv = pending_verts.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.pos_x <= nv.px;
          in_ch.pos_y <= nv.py;
          in_ch.pos_z <= nv.pz;
          in_ch.tex_u <= nv.tu;
          in_ch.tex_v <= nv.tv;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Check face results and stall the result side in bursts
  int stall_out;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_out = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_bases.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          basis_t w;
          w = expected_bases.pop_front();
          if (out_ch.tangent_x !== w.tx) report_mismatch("tangent_x", out_ch.tangent_x, w.tx);
          if (out_ch.tangent_y !== w.ty) report_mismatch("tangent_y", out_ch.tangent_y, w.ty);
          if (out_ch.tangent_z !== w.tz) report_mismatch("tangent_z", out_ch.tangent_z, w.tz);
          if (out_ch.bitangent_x !== w.bx)
            report_mismatch("bitangent_x", out_ch.bitangent_x, w.bx);
          if (out_ch.bitangent_y !== w.by)
            report_mismatch("bitangent_y", out_ch.bitangent_y, w.by);
          if (out_ch.bitangent_z !== w.bz)
            report_mismatch("bitangent_z", out_ch.bitangent_z, w.bz);
          if (out_ch.degenerate !== w.degen)
            report_mismatch("degenerate", out_ch.degenerate, w.degen);
        end
      end
      if (stall_out > 0) begin
        stall_out--;
        out_ch.ready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 40) == 0) begin
        stall_out = $urandom_range(0, 11);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

endmodule

FILE: sim.f
hw/rtl/ttb_pkg.sv
hw/rtl/ttb_if.sv
hw/rtl/ttb_divsqrt.sv
hw/rtl/triangle_tangent_basis_top.sv
sim/tb_top.sv
